// ===== src/smai_pkg.sv =====
// ----------------------------------------------------------------------------
// smai_pkg: shared definitions for the shift / mask / add interpolator
// Operation codes, control field positions and the per-lane shift and mask
// function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smai_pkg;

   // Which interpolator unit this is: unit 0 can blend, unit 1 can clamp.
   localparam int unsigned UNIT_INDEX = 0;

   localparam int unsigned CTRL_W   = 23;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned CSR_IDX_W = 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WR_ACC0  = 3'd0;
   localparam logic [OP_W-1:0] OP_WR_ACC1  = 3'd1;
   localparam logic [OP_W-1:0] OP_WR_BASE0 = 3'd2;
   localparam logic [OP_W-1:0] OP_WR_BASE1 = 3'd3;
   localparam logic [OP_W-1:0] OP_WR_BASE2 = 3'd4;
   localparam logic [OP_W-1:0] OP_WR_PAIR  = 3'd5;
   localparam logic [OP_W-1:0] OP_POP      = 3'd6;
   localparam logic [OP_W-1:0] OP_PEEK     = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LANE0_CTRL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LANE1_CTRL = 1'b1;

   // Control field positions
   localparam int unsigned SHIFT_POS     = 0;
   localparam int unsigned MASK_LSB_POS  = 5;
   localparam int unsigned MASK_MSB_POS  = 10;
   localparam int unsigned SIGNED_BIT    = 15;
   localparam int unsigned CROSS_IN_BIT  = 16;
   localparam int unsigned CROSS_OUT_BIT = 17;
   localparam int unsigned ADD_RAW_BIT   = 18;
   localparam int unsigned FORCE_POS     = 19;
   localparam int unsigned BLEND_BIT     = 21;
   localparam int unsigned CLAMP_BIT     = 22;
   localparam int unsigned FORCE_SHIFT   = 28;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              ovf;
   } lane_out_type;

   // Shift right, mask to [msb:lsb], optionally sign-extend from msb.
   function automatic lane_out_type lane_eval(input logic [CTRL_W-1:0] ctl,
                                              input logic [DATA_W-1:0] data);
      logic [4:0]        sh;
      logic [4:0]        lsb;
      logic [4:0]        msb;
      logic [DATA_W-1:0] msb_mask;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] shifted;
      logic [DATA_W-1:0] v;
      lane_out_type      r;
      sh       = ctl[SHIFT_POS +: 5];
      lsb      = ctl[MASK_LSB_POS +: 5];
      msb      = ctl[MASK_MSB_POS +: 5];
      msb_mask = ~(32'hFFFF_FFFE << msb);
      mask     = msb_mask & (32'hFFFF_FFFF << lsb);
      shifted  = data >> sh;
      v        = shifted & mask;
      r.ovf    = |(shifted & ~msb_mask);
      if (ctl[SIGNED_BIT] && v[msb]) begin
         v = v | (32'hFFFF_FFFF << msb);
      end
      r.value = v;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/shift_mask_add_interpolator.sv =====
// ----------------------------------------------------------------------------
// shift_mask_add_interpolator: two-lane shift / mask / add interpolator
// Register-access front end with accumulators, bases, pop and peek.
// ----------------------------------------------------------------------------
// Each req transaction is one register access (op in req_tuser, value in
// req_tdata); each produces exactly one rsp transaction with all lane results,
// the overflow flags and the accumulators after the access. The block takes
// one transaction per cycle while the output is not stalled: a request sits
// in the input register, where the register write, both lanes (shift, mask,
// sign extend, add), the blend multiply (8 x 34 bits) and the pop writeback
// are evaluated, and the result is loaded into the output register, which
// drives rsp_tvalid. Both stages stall together while rsp_tready is low and
// the output register holds a response, so req_tready follows rsp_tready once
// the pipeline is full. Pop reports the lane results from before its writeback.
// Control registers are written through the csr port and must only change
// while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module shift_mask_add_interpolator (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [31:0]  req_tdata,   // write_data[31:0]
   input  wire logic [2:0]   req_tuser,   // op[2:0]
   // response channel
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // rsp_tdata, lowest bit up: lane_zero_result[31:0], lane_one_result[63:32],
   // combined_result[95:64], lane_zero_full[127:96], lane_one_full[159:128],
   // overflow_zero[160], overflow_one[161], overflow_any[162],
   // accum_zero_now[194:163], accum_one_now[226:195], zero pad[231:227]
   output      logic [231:0] rsp_tdata,
   // configuration write port
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_index,
   input  wire logic [22:0]  csr_wdata
);

   localparam int unsigned DW = smai_pkg::DATA_W;

   // ---------------- control registers ----------------
   logic [smai_pkg::CTRL_W-1:0] ctrl0_ff, ctrl0_in;
   logic [smai_pkg::CTRL_W-1:0] ctrl1_ff, ctrl1_in;

   // ---------------- state ----------------
   logic [DW-1:0] acc0_ff, acc0_in;
   logic [DW-1:0] acc1_ff, acc1_in;
   logic [DW-1:0] base0_ff, base0_in;
   logic [DW-1:0] base1_ff, base1_in;
   logic [DW-1:0] base2_ff, base2_in;

   // ---------------- pipeline ----------------
   logic                      in_valid_ff, in_valid_in;
   logic [smai_pkg::OP_W-1:0] in_op_ff, in_op_in;
   logic [DW-1:0]             in_data_ff, in_data_in;
   logic                      out_valid_ff, out_valid_in;
   logic [231:0]              out_data_ff, out_data_in;

   logic req_fire;
   logic advance;
   logic fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------- register write (state after the access) ----------------
   logic [DW-1:0] acc0_w, acc1_w, base0_w, base1_w, base2_w;
   logic          blend_en;
   logic          clamp_en;
   logic          pair_s0, pair_s1;

   assign blend_en = ctrl0_ff[smai_pkg::BLEND_BIT] && (smai_pkg::UNIT_INDEX == 0);
   assign clamp_en = ctrl0_ff[smai_pkg::CLAMP_BIT] && (smai_pkg::UNIT_INDEX == 1);
   // Base pair: the low half follows lane one's signedness while blending.
   assign pair_s0  = blend_en ? ctrl1_ff[smai_pkg::SIGNED_BIT]
                              : ctrl0_ff[smai_pkg::SIGNED_BIT];
   assign pair_s1  = ctrl1_ff[smai_pkg::SIGNED_BIT];

   always_comb begin
      acc0_w  = acc0_ff;
      acc1_w  = acc1_ff;
      base0_w = base0_ff;
      base1_w = base1_ff;
      base2_w = base2_ff;
      unique case (in_op_ff) inside
         smai_pkg::OP_WR_ACC0:  acc0_w  = in_data_ff;
         smai_pkg::OP_WR_ACC1:  acc1_w  = in_data_ff;
         smai_pkg::OP_WR_BASE0: base0_w = in_data_ff;
         smai_pkg::OP_WR_BASE1: base1_w = in_data_ff;
         smai_pkg::OP_WR_BASE2: base2_w = in_data_ff;
         smai_pkg::OP_WR_PAIR: begin
            base0_w = {{16{pair_s0 & in_data_ff[15]}}, in_data_ff[15:0]};
            base1_w = {{16{pair_s1 & in_data_ff[31]}}, in_data_ff[31:16]};
         end
         smai_pkg::OP_POP, smai_pkg::OP_PEEK: begin
            // read-only accesses: leave state alone
         end
      endcase
   end

   // ---------------- lanes ----------------
   logic [DW-1:0]          lane_in0, lane_in1;
   smai_pkg::lane_out_type lane0, lane1;
   logic [DW-1:0]          add0, add1;
   logic [DW-1:0]          force0, force1;
   logic [7:0]             alpha;

   assign lane_in0 = ctrl0_ff[smai_pkg::CROSS_IN_BIT] ? acc1_w : acc0_w;
   assign lane_in1 = ctrl1_ff[smai_pkg::CROSS_IN_BIT] ? acc0_w : acc1_w;
   assign lane0    = smai_pkg::lane_eval(ctrl0_ff, lane_in0);
   assign lane1    = smai_pkg::lane_eval(ctrl1_ff, lane_in1);
   assign add0     = base0_w + (ctrl0_ff[smai_pkg::ADD_RAW_BIT] ? lane_in0 : lane0.value);
   assign add1     = base1_w + (ctrl1_ff[smai_pkg::ADD_RAW_BIT] ? lane_in1 : lane1.value);
   assign force0   = {2'b00, ctrl0_ff[smai_pkg::FORCE_POS +: 2], 28'd0};
   assign force1   = {2'b00, ctrl1_ff[smai_pkg::FORCE_POS +: 2], 28'd0};
   assign alpha    = lane1.value[7:0];

   // Blend: base0 + floor(alpha * (base1 - base0) / 256), bases extended by
   // lane one's signedness. The arithmetic shift by 8 gives the floor.
   logic                blend_sgn;
   logic [32:0]         b0x, b1x;
   logic signed [33:0]  blend_diff;
   logic signed [8:0]   alpha_s;
   logic signed [42:0]  blend_prod;
   logic [DW-1:0]       blend_val;

   assign blend_sgn  = ctrl1_ff[smai_pkg::SIGNED_BIT];
   assign b0x        = {blend_sgn & base0_w[31], base0_w};
   assign b1x        = {blend_sgn & base1_w[31], base1_w};
   assign blend_diff = $signed({b1x[32], b1x}) - $signed({b0x[32], b0x});
   assign alpha_s    = $signed({1'b0, alpha});
   assign blend_prod = blend_diff * alpha_s;
   assign blend_val  = base0_w + blend_prod[39:8];

   // Clamp lane zero's masked value between base0 and base1.
   logic [DW-1:0] clamp_val;
   logic          below, above;

   always_comb begin
      if (ctrl0_ff[smai_pkg::SIGNED_BIT]) begin
         below = $signed(lane0.value) < $signed(base0_w);
         above = $signed(lane0.value) > $signed(base1_w);
      end else begin
         below = lane0.value < base0_w;
         above = lane0.value > base1_w;
      end
      if (below) begin
         clamp_val = base0_w;
      end else if (above) begin
         clamp_val = base1_w;
      end else begin
         clamp_val = lane0.value;
      end
   end

   logic [DW-1:0] res0, res1, res2;

   always_comb begin
      if (blend_en) begin
         res0 = {24'd0, alpha};
         res1 = blend_val | force1;
      end else begin
         res0 = (clamp_en ? clamp_val : add0) | force0;
         res1 = add1 | force1;
      end
      res2 = base2_w + lane0.value + (blend_en ? '0 : lane1.value);
   end

   // Pop writes the results back, optionally crossed.
   logic          is_pop;
   logic [DW-1:0] acc0_new, acc1_new;

   assign is_pop   = (in_op_ff == smai_pkg::OP_POP);
   assign acc0_new = is_pop ? (ctrl0_ff[smai_pkg::CROSS_OUT_BIT] ? res1 : res0) : acc0_w;
   assign acc1_new = is_pop ? (ctrl1_ff[smai_pkg::CROSS_OUT_BIT] ? res0 : res1) : acc1_w;

   // ---------------- next-state logic ----------------
   always_comb begin
      ctrl0_in = ctrl0_ff;
      ctrl1_in = ctrl1_ff;
      if (csr_we) begin
         unique case (csr_index)
            smai_pkg::CSR_LANE0_CTRL: ctrl0_in = csr_wdata;
            smai_pkg::CSR_LANE1_CTRL: ctrl1_in = csr_wdata;
         endcase
      end

      acc0_in  = fire ? acc0_new : acc0_ff;
      acc1_in  = fire ? acc1_new : acc1_ff;
      base0_in = fire ? base0_w  : base0_ff;
      base1_in = fire ? base1_w  : base1_ff;
      base2_in = fire ? base2_w  : base2_ff;

      // input register: load on accept, drop when passed on
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      in_op_in   = req_fire ? req_tuser : in_op_ff;
      in_data_in = req_fire ? req_tdata : in_data_ff;

      // output register: load when the input stage advances, hold when stalled
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_data_in = fire ? {5'd0, acc1_new, acc0_new, lane0.ovf | lane1.ovf, lane1.ovf,
                            lane0.ovf, lane1.value, lane0.value, res2, res1, res0}
                         : out_data_ff;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff     <= '0;
         ctrl1_ff     <= '0;
         acc0_ff      <= '0;
         acc1_ff      <= '0;
         base0_ff     <= '0;
         base1_ff     <= '0;
         base2_ff     <= '0;
         in_valid_ff  <= 1'b0;
         in_op_ff     <= smai_pkg::OP_PEEK;
         out_valid_ff <= 1'b0;
      end else begin
         ctrl0_ff     <= ctrl0_in;
         ctrl1_ff     <= ctrl1_in;
         acc0_ff      <= acc0_in;
         acc1_ff      <= acc1_in;
         base0_ff     <= base0_in;
         base1_ff     <= base1_in;
         base2_ff     <= base2_in;
         in_valid_ff  <= in_valid_in;
         in_op_ff     <= in_op_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // ---------------- assertions ----------------
   // The reported accumulators always match the state just committed.
   assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_tdata[194:163] == acc0_ff) && (rsp_tdata[226:195] == acc1_ff))
      else $error("reported accumulators differ from committed state");

   // A full, stalled pipeline must not take a new transaction.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while pipeline is full and stalled");

   // The combined overflow flag follows the two lane flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[162] == (rsp_tdata[160] | rsp_tdata[161])))
      else $error("overflow_any inconsistent with lane flags");

endmodule

`default_nettype wire
